>>> hdl/olid_pkg.sv
// olid_pkg: shared codes, port widths, defaults and the cell command bundle
// for the ordered list block; no dependencies
`default_nettype none

package olid_pkg;

    // default sizes
    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed port widths
    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int DIN_W = 32;
    localparam int ST_W  = 3;
    localparam int LEN_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // broadcast command from the controller to every cell
    typedef struct packed {
        logic append;
        logic insert;
        logic delete_at;
        logic write_at;
        logic find;
        logic read;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> hdl/olid_cell.sv
// olid_cell: one list slot; holds an entry, shifts with its neighbors and
// passes the search result one slot further each cycle; uses olid_pkg
`default_nettype none

module olid_cell import olid_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int IDX        = 0
) (
    input  wire logic                          i_clk,
    input  wire t_cell_cmd                     i_cmd,
    input  wire logic [((($clog2(CAPACITY+1)) > POS_W) ? $clog2(CAPACITY+1) : POS_W)-1:0] i_pos,
    input  wire logic [((($clog2(CAPACITY+1)) > POS_W) ? $clog2(CAPACITY+1) : POS_W)-1:0] i_count,
    input  wire logic [DATA_WIDTH-1:0]         i_key,
    input  wire logic [DATA_WIDTH-1:0]         i_left,
    input  wire logic [DATA_WIDTH-1:0]         i_right,
    input  wire logic                          i_hit,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_fidx,
    input  wire logic [DATA_WIDTH-1:0]         i_fdat,
    output logic      [DATA_WIDTH-1:0]         o_entry,
    output logic                               o_hit,
    output logic      [$clog2(CAPACITY)-1:0]   o_fidx,
    output logic      [DATA_WIDTH-1:0]         o_fdat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = (CW > POS_W) ? CW : POS_W;
    localparam logic [EW:0]   MY  = (EW+1)'(IDX);
    localparam logic [EW:0]   MY1 = (EW+1)'(IDX + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_WIDTH-1:0] r_entry, n_entry;
    logic                  r_hit, n_hit;
    logic [IW-1:0]         r_fidx, n_fidx;
    logic [DATA_WIDTH-1:0] r_fdat, n_fdat;
    logic [EW:0]           pos_x, cnt_x;
    logic                  sel;

    assign pos_x = {1'b0, i_pos};
    assign cnt_x = {1'b0, i_count};

    // entry update: load, shift from a neighbor or hold
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.append && MY == cnt_x) begin
            n_entry = i_key;
        end
        if (i_cmd.insert) begin
            if (MY == pos_x) begin
                n_entry = i_key;
            end else if (MY > pos_x && MY <= cnt_x) begin
                n_entry = i_left;
            end
        end
        if (i_cmd.delete_at && MY >= pos_x && MY1 < cnt_x) begin
            n_entry = i_right;
        end
        if (i_cmd.write_at && MY == pos_x) begin
            n_entry = i_key;
        end
    end

    // this slot answers a read at its index or a find that matches it
    assign sel = (i_cmd.read && MY == pos_x) ||
                 (i_cmd.find && MY < cnt_x && r_entry == i_key);

    // first hit from the head side wins and travels on unchanged
    always_comb begin
        if (i_hit) begin
            n_hit  = 1'b1;
            n_fidx = i_fidx;
            n_fdat = i_fdat;
        end else if (sel) begin
            n_hit  = 1'b1;
            n_fidx = MY_IDX;
            n_fdat = r_entry;
        end else begin
            n_hit  = 1'b0;
            n_fidx = '0;
            n_fdat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
        r_fidx  <= n_fidx;
        r_fdat  <= n_fdat;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_fidx  = r_fidx;
    assign o_fdat  = r_fdat;

endmodule

`default_nettype wire

>>> hdl/olid_ctrl.sv
// olid_ctrl: request capture, status checks, element count, scan timing and
// result registers for the ordered list; uses olid_pkg
`default_nettype none

module olid_ctrl import olid_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [OP_W-1:0]             i_operation,
    input  wire logic [POS_W-1:0]            i_position,
    input  wire logic [DIN_W-1:0]            i_data_in,
    input  wire logic                        i_tail_hit,
    input  wire logic [$clog2(CAPACITY)-1:0] i_tail_fidx,
    input  wire logic [DATA_WIDTH-1:0]       i_tail_fdat,
    output t_cell_cmd                        o_cmd,
    output logic [((($clog2(CAPACITY+1)) > POS_W) ? $clog2(CAPACITY+1) : POS_W)-1:0] o_pos,
    output logic [((($clog2(CAPACITY+1)) > POS_W) ? $clog2(CAPACITY+1) : POS_W)-1:0] o_count,
    output logic [DATA_WIDTH-1:0]            o_key,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [ST_W-1:0]                  o_status,
    output logic [POS_W-1:0]                 o_found_index,
    output logic [DIN_W-1:0]                 o_data_out,
    output logic [LEN_W-1:0]                 o_length,
    output logic                             o_empty_flag
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = (CW > POS_W) ? CW : POS_W;
    localparam int XW = (DATA_WIDTH > DIN_W) ? DATA_WIDTH : DIN_W;
    localparam int FW = (IW > POS_W) ? IW : POS_W;
    localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
    localparam logic [IW-1:0] SCAN_LAST = IW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_scan, n_scan;
    logic                  r_done, n_done;
    logic [ST_W-1:0]       r_status, n_status;
    logic [POS_W-1:0]      r_fidx, n_fidx;
    logic [DIN_W-1:0]      r_dout, n_dout;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_empty, n_empty;

    logic [XW-1:0] key_x, dat_x;
    logic [FW-1:0] fidx_x;
    logic [EW-1:0] pos_e, cnt_e;
    logic          is_full, is_zero, pos_past, pos_out;

    assign key_x  = XW'(i_data_in);
    assign dat_x  = XW'(i_tail_fdat);
    assign fidx_x = FW'(i_tail_fidx);

    // checks against the current count
    assign pos_e    = EW'(r_pos);
    assign cnt_e    = EW'(r_count);
    assign is_full  = (r_count == CAP_C);
    assign is_zero  = (r_count == '0);
    assign pos_past = (pos_e > cnt_e);
    assign pos_out  = (pos_e >= cnt_e);

    // cell commands: list changes only in the execute cycle and only on success
    always_comb begin
        o_cmd           = '0;
        o_cmd.find      = (r_op == OP_FIND);
        o_cmd.read      = (r_op == OP_READ);
        if (r_state == S_EXEC) begin
            o_cmd.append    = (r_op == OP_APPEND) && !is_full;
            o_cmd.insert    = (r_op == OP_INSERT) && !is_full && !pos_past;
            o_cmd.delete_at = (r_op == OP_DELETE) && !pos_out;
            o_cmd.write_at  = (r_op == OP_WRITE) && !pos_out;
        end
    end

    // sequencing and results
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pos    = r_pos;
        n_key    = r_key;
        n_count  = r_count;
        n_scan   = r_scan;
        n_done   = 1'b0;
        n_status = r_status;
        n_fidx   = r_fidx;
        n_dout   = r_dout;
        n_len    = r_len;
        n_empty  = r_empty;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_operation;
                    n_pos   = i_position;
                    n_key   = key_x[DATA_WIDTH-1:0];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_fidx   = '0;
                n_dout   = '0;
                n_done   = 1'b1;
                n_state  = S_IDLE;
                case (r_op)
                    OP_APPEND: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else if (pos_past) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (is_zero) begin
                            n_status = ST_EMPTY;
                        end else if (pos_out) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_WRITE: begin
                        if (is_zero) begin
                            n_status = ST_EMPTY;
                        end else if (pos_out) begin
                            n_status = ST_BADPOS;
                        end
                    end
                    OP_READ: begin
                        if (is_zero) begin
                            n_status = ST_EMPTY;
                        end else if (pos_out) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_done  = 1'b0;
                            n_scan  = '0;
                            n_state = S_SCAN;
                        end
                    end
                    OP_FIND: begin
                        n_done  = 1'b0;
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
                n_len   = LEN_W'(n_count);
                n_empty = (n_count == '0);
            end
            S_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == SCAN_LAST) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_FIND) begin
                        n_status = i_tail_hit ? ST_OK : ST_NOTFOUND;
                        n_fidx   = i_tail_hit ? fidx_x[POS_W-1:0] : '0;
                        n_dout   = '0;
                    end else begin
                        n_status = ST_OK;
                        n_fidx   = '0;
                        n_dout   = dat_x[DIN_W-1:0];
                    end
                    n_len   = LEN_W'(n_count);
                    n_empty = (n_count == '0);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_scan   <= n_scan;
        r_status <= n_status;
        r_fidx   <= n_fidx;
        r_dout   <= n_dout;
        r_len    <= n_len;
        r_empty  <= n_empty;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    assign o_pos         = pos_e;
    assign o_count       = cnt_e;
    assign o_key         = r_key;
    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_index = r_fidx;
    assign o_data_out    = r_dout;
    assign o_length      = r_len;
    assign o_empty_flag  = r_empty;

endmodule

`default_nettype wire

>>> hdl/ordered_list_insert_delete.sv
// ordered_list_insert_delete: top level of the ordered list, a controller and
// a row of CAPACITY list cells; uses olid_pkg, olid_ctrl and olid_cell
//
//   channel  | handshake        | word
//   ---------+------------------+---------------------------------------------
//   request  | start, busy      | i_operation, i_position, i_data_in
//   result   | o_done (strobe)  | o_status, o_found_index, o_data_out,
//            |                  | o_length, o_empty_flag
//
// A request is taken when start is high and busy is low. Append, insert,
// delete, write, clear, unused codes and failed requests other than find go
// from the execute state straight to the o_done strobe; every cell shifts or
// loads in the same cycle. Find and a successful read also pass a scan state
// while the first hit walks down the cell row one cell per cycle. busy is
// already low in the o_done cycle, so the next request can be taken at the edge that ends it.
// Reset empties the list at once; results cannot be held off by the receiver.
`default_nettype none

module ordered_list_insert_delete import olid_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [DIN_W-1:0]  i_data_in,
    output logic                   o_done,
    output logic [ST_W-1:0]        o_status,
    output logic [POS_W-1:0]       o_found_index,
    output logic [DIN_W-1:0]       o_data_out,
    output logic [LEN_W-1:0]       o_length,
    output logic                   o_empty_flag
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    t_cell_cmd             cmd;
    logic [EW-1:0]         pos_b, cnt_b;
    logic [DATA_WIDTH-1:0] key_b;
    logic [DATA_WIDTH-1:0] w_entry [CAPACITY];
    logic                  w_hit   [CAPACITY];
    logic [IW-1:0]         w_fidx  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_fdat  [CAPACITY];

    // controller
    olid_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_data_in     (i_data_in),
        .i_tail_hit    (w_hit[CAPACITY-1]),
        .i_tail_fidx   (w_fidx[CAPACITY-1]),
        .i_tail_fdat   (w_fdat[CAPACITY-1]),
        .o_cmd         (cmd),
        .o_pos         (pos_b),
        .o_count       (cnt_b),
        .o_key         (key_b),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_data_out    (o_data_out),
        .o_length      (o_length),
        .o_empty_flag  (o_empty_flag)
    );

    // row of cells, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d, right_d, prev_fdat;
        logic                  prev_hit;
        logic [IW-1:0]         prev_fidx;

        if (g == 0) begin : g_head
            assign left_d    = key_b;
            assign prev_hit  = 1'b0;
            assign prev_fidx = '0;
            assign prev_fdat = '0;
        end else begin : g_body
            assign left_d    = w_entry[g-1];
            assign prev_hit  = w_hit[g-1];
            assign prev_fidx = w_fidx[g-1];
            assign prev_fdat = w_fdat[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_d = w_entry[g];
        end else begin : g_inner
            assign right_d = w_entry[g+1];
        end

        olid_cell #(
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (pos_b),
            .i_count (cnt_b),
            .i_key   (key_b),
            .i_left  (left_d),
            .i_right (right_d),
            .i_hit   (prev_hit),
            .i_fidx  (prev_fidx),
            .i_fdat  (prev_fdat),
            .o_entry (w_entry[g]),
            .o_hit   (w_hit[g]),
            .o_fidx  (w_fidx[g]),
            .o_fdat  (w_fdat[g])
        );
    end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// tb_top: self-checking bench for ordered_list_insert_delete with directed edge cases,
// a full-list pass and random traffic under sender idling; uses olid_pkg and the block
`default_nettype none

module tb_top;
    import olid_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int SLOW_LATENCY = CAPACITY + 2;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_GAP      = 20;

    // code seven does nothing and still answers
    localparam logic [OP_W-1:0] OP_NOP = 3'd7;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] found_index;
        logic [DIN_W-1:0] data_out;
        logic [LEN_W-1:0] length;
        logic             empty_flag;
    } t_list_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_operation;
    logic [POS_W-1:0]   i_position;
    logic [DIN_W-1:0]   i_data_in;
    logic               o_done;
    logic [ST_W-1:0]    o_status;
    logic [POS_W-1:0]   o_found_index;
    logic [DIN_W-1:0]   o_data_out;
    logic [LEN_W-1:0]   o_length;
    logic               o_empty_flag;

    // predicted list contents and length
    logic [DIN_W-1:0]   list_words [CAPACITY];
    int                 list_len;

    t_list_result       pending_results [$];
    int                 error_count;
    int                 cycle_count;
    int                 sender_idle_pct;

    ordered_list_insert_delete dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_data_in     (i_data_in),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_data_out    (o_data_out),
        .o_length      (o_length),
        .o_empty_flag  (o_empty_flag)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle count for messages
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // hard stop if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 CYCLE_LIMIT, pending_results.size());
        $display("ordered_list_insert_delete test failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // apply one request to the predicted list and return its result word
    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DIN_W-1:0] data);
        t_list_result res;
        int p;
        int i;
        res.status      = ST_OK;
        res.found_index = '0;
        res.data_out    = '0;
        p = int'(pos);
        case (op)
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = data;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
                    list_words[p] = data;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    // tail moves down, nothing past the last element is read
                    for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_FIND: begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (res.status == ST_NOTFOUND && list_words[i] == data) begin
                        res.status      = ST_OK;
                        res.found_index = i[POS_W-1:0];
                    end
                end
            end
            OP_READ: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.data_out = list_words[p];
                end
            end
            OP_WRITE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    list_words[p] = data;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.length     = list_len[LEN_W-1:0];
        res.empty_flag = (list_len == 0);
        return res;
    endfunction

    // send one request word; start stays high on return so a back-to-back
    // word needs no second assignment in the same step
    task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DIN_W-1:0] data);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_data_in   <= data;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_list_op(op, pos, data));
    endtask

    // hold off until every result is in, then let the block settle
    task automatic wait_results_drained(input int settle_cycles);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result with none pending: status %0d length %0d",
                                     o_status, o_length));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    flag_error($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_found_index !== want.found_index)
                    flag_error($sformatf("found_index %0d, want %0d",
                                         o_found_index, want.found_index));
                if (o_data_out !== want.data_out)
                    flag_error($sformatf("data_out %h, want %h", o_data_out, want.data_out));
                if (o_length !== want.length)
                    flag_error($sformatf("length %0d, want %0d", o_length, want.length));
                if (o_empty_flag !== want.empty_flag)
                    flag_error($sformatf("empty_flag %b, want %b",
                                         o_empty_flag, want.empty_flag));
            end
        end
    end

    // status checks on an empty and a short list, shifts at both ends
    task automatic test_directed_cases();
        send_word(OP_DELETE, 7'd0, 32'h0);
        send_word(OP_READ, 7'd0, 32'h0);
        send_word(OP_WRITE, 7'd0, 32'h1111_1111);
        send_word(OP_FIND, 7'd0, 32'h0);
        send_word(OP_INSERT, 7'd1, 32'h2222_2222);
        send_word(OP_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_APPEND, 7'd0, 32'h0000_0000);
        send_word(OP_APPEND, 7'd127, 32'h5A5A_A5A5);
        // insert right at the end of the list
        send_word(OP_INSERT, 7'd3, 32'h0000_0001);
        send_word(OP_INSERT, 7'd1, 32'h0000_0000);
        // duplicate zero: first match wins
        send_word(OP_FIND, 7'd0, 32'h0000_0000);
        send_word(OP_FIND, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_FIND, 7'd0, 32'h1234_5678);
        send_word(OP_READ, 7'd4, 32'h0);
        send_word(OP_READ, 7'd5, 32'h0);
        send_word(OP_READ, 7'd127, 32'h0);
        send_word(OP_WRITE, 7'd2, 32'h8000_0000);
        send_word(OP_WRITE, 7'd127, 32'h7FFF_FFFF);
        send_word(OP_DELETE, 7'd127, 32'h0);
        send_word(OP_DELETE, 7'd4, 32'h0);
        send_word(OP_DELETE, 7'd0, 32'h0);
        send_word(OP_NOP, 7'd127, 32'hFFFF_FFFF);
        send_word(OP_READ, 7'd1, 32'h0);
        send_word(OP_CLEAR, 7'd0, 32'h0);
        send_word(OP_FIND, 7'd0, 32'h8000_0000);
    endtask

    // fill to capacity, then full checks and shifts across the whole row
    task automatic test_full_list();
        int k;
        logic [DIN_W-1:0] last_word;
        send_word(OP_CLEAR, 7'd0, 32'h0);
        for (k = 0; k < CAPACITY; k++)
            send_word(OP_APPEND, 7'($urandom_range(127)), $urandom());
        send_word(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 7'd127, 32'h0);
        send_word(OP_READ, 7'd127, 32'h0);
        send_word(OP_WRITE, 7'd127, 32'hC0DE_F00D);
        send_word(OP_FIND, 7'd0, 32'hC0DE_F00D);
        last_word = list_words[CAPACITY-1];
        send_word(OP_DELETE, 7'd127, 32'h0);
        // the stale top entry must no longer match
        send_word(OP_FIND, 7'd0, last_word);
        send_word(OP_INSERT, 7'd127, 32'hAAAA_5555);
        send_word(OP_DELETE, 7'd0, 32'h0);
        send_word(OP_INSERT, 7'd0, 32'h0000_0000);
        send_word(OP_READ, 7'd0, 32'h0);
        send_word(OP_FIND, 7'd0, 32'hAAAA_5555);
    endtask

    // random traffic steering the length toward a moving target
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int k;
        int r;
        int len_target;
        int grow_w;
        int shrink_w;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [DIN_W-1:0] data;
        sender_idle_pct = idle_pct;
        len_target = 8;
        for (k = 0; k < n_items; k++) begin
            if (k % 80 == 0) begin
                case ($urandom_range(3))
                    0:       len_target = 4;
                    1:       len_target = 24;
                    2:       len_target = 80;
                    default: len_target = CAPACITY;
                endcase
            end
            grow_w   = (list_len < len_target) ? 40 : 15;
            shrink_w = (list_len > len_target) ? 35 : 12;
            r = $urandom_range(99);
            if (r < 2) begin
                op = OP_CLEAR;
            end else if (r < 4) begin
                op = OP_NOP;
            end else if (r < 4 + grow_w) begin
                op = $urandom_range(1) ? OP_INSERT : OP_APPEND;
            end else if (r < 4 + grow_w + shrink_w) begin
                op = OP_DELETE;
            end else begin
                case ($urandom_range(2))
                    0:       op = OP_FIND;
                    1:       op = OP_READ;
                    default: op = OP_WRITE;
                endcase
            end

            // positions mostly in range, with ends and junk mixed in
            r = $urandom_range(9);
            if (r == 0)
                pos = 7'($urandom_range(127));
            else if (r == 1)
                pos = '0;
            else if (op == OP_INSERT)
                pos = 7'((r == 2) ? list_len : $urandom_range(list_len));
            else if (list_len == 0)
                pos = 7'($urandom_range(3));
            else
                pos = 7'((r == 2) ? list_len - 1 : $urandom_range(list_len - 1));

            // few distinct small values give duplicates for find
            r = $urandom_range(9);
            if (op == OP_FIND && list_len > 0 && r < 6)
                data = list_words[$urandom_range(list_len - 1)];
            else if (r < 3)
                data = DIN_W'($urandom_range(7));
            else if (r == 3)
                data = $urandom_range(1) ? '1 : 32'h8000_0000;
            else
                data = $urandom();

            send_word(op, pos, data);
        end
    endtask

    // stimulus sequence
    initial begin
        error_count     = 0;
        cycle_count     = 0;
        list_len        = 0;
        sender_idle_pct = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_APPEND;
        i_position  <= '0;
        i_data_in   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        wait_results_drained(2);

        sender_idle_pct = 18;
        test_full_list();
        wait_results_drained(2);

        test_random_traffic(310, 0);
        wait_results_drained(2);
        test_random_traffic(310, 77);
        // sender pauses until every result is in
        wait_results_drained(0);
        test_random_traffic(310, 0);
        wait_results_drained(2);
        test_random_traffic(310, 18);

        wait_results_drained(SLOW_LATENCY + 4);
        if (error_count == 0) begin
            $display("ordered_list_insert_delete test passed");
        end else begin
            $display("ordered_list_insert_delete test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/olid_pkg.sv
hdl/olid_cell.sv
hdl/olid_ctrl.sv
hdl/ordered_list_insert_delete.sv
test/tb_top.sv
